>>> hdl/lpc_pkg.sv
`default_nettype none
package lpc_pkg;

   // Field widths and limits
   localparam int MAX_SIDE = 32;
   localparam int SIDE_W   = 6;
   localparam int COUNT_W  = 59;
   localparam int ACC_W    = 64;
   localparam int REM_W    = 5;
   localparam int CNT_W    = 6;
   localparam int PC_W     = 3;

   // Datapath operations
   localparam logic [2:0] OP_NOP  = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_EMIT = 3'd4;

   // Jump conditions
   localparam logic [2:0] CND_NEVER    = 3'd0;
   localparam logic [2:0] CND_ALWAYS   = 3'd1;
   localparam logic [2:0] CND_NO_REQ   = 3'd2;
   localparam logic [2:0] CND_K_DONE   = 3'd3;
   localparam logic [2:0] CND_K_MORE   = 3'd4;
   localparam logic [2:0] CND_DIV_MORE = 3'd5;
   localparam logic [2:0] CND_RSP_BUSY = 3'd6;

   // Program steps
   localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [PC_W-1:0] STEP_CHECK = 3'd1;
   localparam logic [PC_W-1:0] STEP_MUL   = 3'd2;
   localparam logic [PC_W-1:0] STEP_DIV   = 3'd3;
   localparam logic [PC_W-1:0] STEP_LOOP  = 3'd4;
   localparam logic [PC_W-1:0] STEP_EMIT  = 3'd5;
   localparam logic [PC_W-1:0] STEP_DONE  = 3'd6;

   typedef struct packed {
      logic [2:0]      op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } lpc_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic k_done;
      logic div_last;
      logic rsp_busy;
   } lpc_status_type;

   // Microcode table: one control word per step
   function automatic lpc_ctrl_type lpc_ucode(input logic [PC_W-1:0] pc);
      lpc_ctrl_type w;
      case (pc)
         STEP_WAIT:  w = '{op: OP_LOAD, cond: CND_NO_REQ,   target: STEP_WAIT};
         STEP_CHECK: w = '{op: OP_NOP,  cond: CND_K_DONE,   target: STEP_EMIT};
         STEP_MUL:   w = '{op: OP_MUL,  cond: CND_NEVER,    target: STEP_WAIT};
         STEP_DIV:   w = '{op: OP_DIV,  cond: CND_DIV_MORE, target: STEP_DIV};
         STEP_LOOP:  w = '{op: OP_NOP,  cond: CND_K_MORE,   target: STEP_MUL};
         STEP_EMIT:  w = '{op: OP_EMIT, cond: CND_RSP_BUSY, target: STEP_EMIT};
         STEP_DONE:  w = '{op: OP_NOP,  cond: CND_ALWAYS,   target: STEP_WAIT};
         default:    w = '{op: OP_NOP,  cond: CND_ALWAYS,   target: STEP_WAIT};
      endcase
      return w;
   endfunction

   // Zero side reads as 1, oversized side saturates
   function automatic logic [SIDE_W-1:0] lpc_clamp(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/lpc_if.sv
`default_nettype none
interface lpc_req_if import lpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] rows;
   logic [SIDE_W-1:0] cols;

   modport source (output valid, output rows, output cols, input ready);
   modport sink   (input valid, input rows, input cols, output ready);
endinterface

interface lpc_rsp_if import lpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] path_count;

   modport source (output valid, output path_count, input ready);
   modport sink   (input valid, input path_count, output ready);
endinterface
`default_nettype wire

>>> hdl/lpc_sequencer.sv
`default_nettype none
module lpc_sequencer import lpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lpc_status_type  status,
   output lpc_ctrl_type    ctrl,
   output logic [PC_W-1:0] step
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            jump;

   // Control word for the current step
   assign ctrl = lpc_ucode(pc_ff);
   assign step = pc_ff;

   // Jump condition select
   always_comb begin
      case (ctrl.cond)
         CND_NEVER:    jump = 1'b0;
         CND_ALWAYS:   jump = 1'b1;
         CND_NO_REQ:   jump = !status.req_valid;
         CND_K_DONE:   jump = status.k_done;
         CND_K_MORE:   jump = !status.k_done;
         CND_DIV_MORE: jump = !status.div_last;
         CND_RSP_BUSY: jump = status.rsp_busy;
         default:      jump = 1'b1;
      endcase
   end

   assign pc_in = jump ? ctrl.target : pc_ff + PC_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/lpc_datapath.sv
`default_nettype none
module lpc_datapath import lpc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  lpc_ctrl_type   ctrl,
   output lpc_status_type status,
   lpc_req_if.sink        req_ch,
   lpc_rsp_if.source      rsp_ch
);

   logic [SIDE_W-1:0]         rows_ff, cols_ff, k_ff;
   logic [SIDE_W-1:0]         rows_in, cols_in, k_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      take;
   logic                      emit;
   logic [SIDE_W-1:0]         factor;
   logic [ACC_W-1:0]          product;
   logic [REM_W:0]            rem_sh;
   logic                      fits;

   assign req_ch.ready = (ctrl.op == OP_LOAD);
   assign take         = req_ch.valid && req_ch.ready;

   assign status.req_valid = req_ch.valid;
   assign status.k_done    = (k_ff >= rows_ff);
   assign status.div_last  = &cnt_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ch.ready;

   // Multiplier: acc stays below 2^59 before each multiply, product below 2^64
   assign factor  = cols_ff + k_ff - SIDE_W'(1);
   assign product = {{(ACC_W-COUNT_W){1'b0}}, acc_ff[COUNT_W-1:0]} * ACC_W'(factor);

   // One restoring division step: remainder stays below k
   assign rem_sh = {rem_ff, acc_ff[ACC_W-1]};
   assign fits   = (rem_sh >= k_ff);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      k_in    = k_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      case (ctrl.op)
         OP_LOAD: begin
            if (take) begin
               rows_in = lpc_clamp(req_ch.rows);
               cols_in = lpc_clamp(req_ch.cols);
               k_in    = SIDE_W'(1);
               acc_in  = ACC_W'(1);
            end
         end
         OP_MUL: begin
            acc_in = product;
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV: begin
            acc_in = {acc_ff[ACC_W-2:0], fits};
            rem_in = fits ? REM_W'(rem_sh - k_ff) : rem_sh[REM_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (&cnt_ff) begin
               k_in = k_ff + SIDE_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      cols_ff <= cols_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   // Result register
   assign emit         = (ctrl.op == OP_EMIT) && !status.rsp_busy;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_count_in = emit ? acc_ff[COUNT_W-1:0] : rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.path_count = rsp_count_ff;

endmodule
`default_nettype wire

>>> hdl/lattice_path_count_core.sv
`default_nettype none
// Lattice path counter: each request gives rows and cols (1 to 32; zero reads as 1 and
// larger values saturate at 32) and the response is the exact count of monotone paths
// between opposite corners, C(rows+cols-2, rows-1), 59 bits. The count is built by a
// small microcoded sequencer over a multiply-and-divide datapath: for k = 1 to rows-1 the
// running product is multiplied by (cols-1+k) and then divided exactly by k with a
// restoring divider that retires one quotient bit per cycle. One request is in work at
// a time; the next one is taken in the wait step, which the sequencer reaches through
// the done step after the previous result is loaded into the output register, even if
// it has not yet been read.
module lattice_path_count_core import lpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lpc_req_if.sink   req_ch,
   lpc_rsp_if.source rsp_ch
);

   lpc_ctrl_type    ctrl;
   lpc_status_type  status;
   logic [PC_W-1:0] step;

   lpc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   lpc_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // An accepted request always moves on to the first loop check
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (step == STEP_CHECK))
      else $error("accepted request did not start the loop");

   // A result leaves the output register only when the consumer takes it
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_ch.valid) |-> $past(rsp_ch.ready))
      else $error("response dropped without handshake");

   // A path count is never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.path_count != '0))
      else $error("zero path count");

   // No request is taken while the sequencer is busy
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (step == STEP_WAIT))
      else $error("request taken outside the wait step");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
   import lpc_pkg::*;

   // Watchdog limit, drain time and number of random grids
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int DRAIN_CYCLES = 2100;
   localparam int RANDOM_GRIDS = 268;

   typedef struct {
      logic [SIDE_W-1:0]  rows;
      logic [SIDE_W-1:0]  cols;
      logic [COUNT_W-1:0] count;
   } grid_expect_type;

   logic clock;
   logic reset;
   int   error_count;
   int   cycle_count;
   int   stall_left;
   bit   quiet_mode;

   grid_expect_type pending_counts[$];

   lpc_req_if req_bus ();
   lpc_rsp_if rsp_bus ();

   lattice_path_count_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Side value as the counter sees it: zero reads as one, large values saturate
   function automatic bit [63:0] grid_side(input logic [SIDE_W-1:0] raw);
      bit [63:0] side;
      side = 64'(raw);
      if (side == 0) begin
         side = 1;
      end else if (side > MAX_SIDE) begin
         side = MAX_SIDE;
      end
      return side;
   endfunction

   // Exact corner-to-corner path count, C(rows+cols-2, rows-1)
   function automatic logic [COUNT_W-1:0] paths_through_grid(
      input logic [SIDE_W-1:0] rows_in,
      input logic [SIDE_W-1:0] cols_in
   );
      bit [63:0] height;
      bit [63:0] width;
      bit [63:0] product;
      height  = grid_side(rows_in);
      width   = grid_side(cols_in);
      product = 1;
      for (bit [63:0] k = 1; k < height; k++) begin
         product = product * (width - 1 + k);
         product = product / k;
      end
      return product[COUNT_W-1:0];
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (quiet_mode) begin
         rsp_bus.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = idle_length();
      end
   end

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      grid_expect_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         want.rows  = req_bus.rows;
         want.cols  = req_bus.cols;
         want.count = paths_through_grid(req_bus.rows, req_bus.cols);
         pending_counts.push_back(want);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual path_count %0d",
                     $time, rsp_bus.path_count);
            error_count++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_bus.path_count !== want.count) begin
               $display("%0t: rows %0d cols %0d path_count expected %0d actual %0d",
                        $time, want.rows, want.cols, want.count, rsp_bus.path_count);
               error_count++;
            end
         end
      end
   end

   // Present one grid and hold it until the core takes it
   task automatic send_grid(input logic [SIDE_W-1:0] rows, input logic [SIDE_W-1:0] cols);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.rows  <= rows;
      req_bus.cols  <= cols;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
   endtask

   task automatic pause_source(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic send_paced(input logic [SIDE_W-1:0] rows, input logic [SIDE_W-1:0] cols);
      send_grid(rows, cols);
      if (!quiet_mode) pause_source(idle_length());
   endtask

   // Single row or column gives exactly one path; sent back to back
   task automatic test_single_line();
      quiet_mode = 1'b1;
      send_paced(6'd1, 6'd1);
      send_paced(6'd1, 6'd32);
      send_paced(6'd32, 6'd1);
      send_paced(6'd1, 6'd17);
      send_paced(6'd9, 6'd1);
      quiet_mode = 1'b0;
   endtask

   // Largest grids, the near-square cases that stress the 59-bit count, and two-wide grids
   task automatic test_side_extremes();
      send_paced(6'd32, 6'd32);
      send_paced(6'd2, 6'd2);
      send_paced(6'd2, 6'd32);
      send_paced(6'd32, 6'd2);
      send_paced(6'd31, 6'd32);
      send_paced(6'd32, 6'd31);
      send_paced(6'd16, 6'd16);
   endtask

   // Zero sides read as one, oversized sides saturate
   task automatic test_side_clamp();
      send_paced(6'd0, 6'd0);
      send_paced(6'd0, 6'd32);
      send_paced(6'd32, 6'd0);
      send_paced(6'd63, 6'd63);
      send_paced(6'd33, 6'd33);
      send_paced(6'd63, 6'd1);
      send_paced(6'd0, 6'd63);
      send_paced(6'd40, 6'd5);
      send_paced(6'd5, 6'd40);
      send_paced(6'd48, 6'd0);
   endtask

   // Random grids: mostly short heights to keep the run short, some full range
   task automatic test_random_grids();
      logic [SIDE_W-1:0] rows;
      logic [SIDE_W-1:0] cols;
      for (int n = 0; n < RANDOM_GRIDS; n++) begin
         if (n % 40 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 80) begin
            rows = SIDE_W'($urandom_range(0, 10));
         end else begin
            rows = SIDE_W'($urandom_range(0, 63));
         end
         cols = SIDE_W'($urandom_range(0, 63));
         send_paced(rows, cols);
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      error_count   = 0;
      cycle_count   = 0;
      stall_left    = 0;
      quiet_mode    = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.rows  = '0;
      req_bus.cols  = '0;
      rsp_bus.ready = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_line();
      test_side_extremes();
      test_side_clamp();
      test_random_grids();

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain, then watch for stray responses
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
